// ===== rtl/stsr_pkg.sv =====
// Shared constants, codes and types of the segmented transfer session receiver.
`timescale 1ns / 1ps

package stsr_pkg;

  localparam int SLOTS   = 3;
  localparam int SLOT_W  = 2;
  localparam int ID_W    = 16;
  localparam int CNT_W   = 16;
  localparam int BYTES_W = 22;
  localparam int TIME_W  = 32;
  localparam int PM_W    = 7;
  localparam int LIM_W   = 23;
  localparam int LEN_W   = 7;
  localparam int PROD_W  = CNT_W + PM_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int MODE_W  = 3;
  localparam int CODE_W  = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 5;

  localparam logic [MODE_W-1:0] MODE_START = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DATA  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_END   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd4;

  localparam logic [CODE_W-1:0] RC_CRC_ERR   = 4'd0;
  localparam logic [CODE_W-1:0] RC_EXISTS    = 4'd1;
  localparam logic [CODE_W-1:0] RC_NO_SLOT   = 4'd2;
  localparam logic [CODE_W-1:0] RC_NO_MEM    = 4'd3;
  localparam logic [CODE_W-1:0] RC_START_OK  = 4'd4;
  localparam logic [CODE_W-1:0] RC_INVALID   = 4'd5;
  localparam logic [CODE_W-1:0] RC_BAD_INDEX = 4'd6;
  localparam logic [CODE_W-1:0] RC_DATA_OK   = 4'd7;
  localparam logic [CODE_W-1:0] RC_OVERFLOW  = 4'd8;
  localparam logic [CODE_W-1:0] RC_MISSING   = 4'd9;
  localparam logic [CODE_W-1:0] RC_END_OK    = 4'd10;
  localparam logic [CODE_W-1:0] RC_SCAN_DONE = 4'd11;

  localparam logic [1:0] REG_PAYLOAD_MAX  = 2'd0;
  localparam logic [1:0] REG_BUFFER_LIMIT = 2'd1;
  localparam logic [1:0] REG_TIMEOUT      = 2'd2;

  localparam logic [PM_W-1:0]   PAYLOAD_MAX_RST  = 7'd48;
  localparam logic [LIM_W-1:0]  BUFFER_LIMIT_RST = 23'd65536;
  localparam logic [TIME_W-1:0] TIMEOUT_RST      = 32'd5000;

  typedef struct packed {
    logic [PM_W-1:0]   payload_max;
    logic [LIM_W-1:0]  buffer_limit;
    logic [TIME_W-1:0] idle_limit;
  } cfg_t;

  typedef struct packed {
    logic               active;
    logic [ID_W-1:0]    session;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   received;
    logic [BYTES_W-1:0] bytes;
    logic [TIME_W-1:0]  last_time;
  } slot_t;

  typedef struct packed {
    logic               op_open;
    logic               op_update;
    logic               op_free;
    logic [SLOT_W-1:0]  idx;
    logic [ID_W-1:0]    session;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   received;
    logic [BYTES_W-1:0] bytes;
    logic [TIME_W-1:0]  last_time;
  } slot_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

endpackage

// ===== rtl/stsr_cfg.sv =====
// Configuration register file with APB-style access.
`timescale 1ns / 1ps

module stsr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [stsr_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [stsr_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [stsr_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output stsr_pkg::cfg_t                cfg
);

  logic [stsr_pkg::PM_W-1:0]   payload_max_r;
  logic [stsr_pkg::LIM_W-1:0]  buffer_limit_r;
  logic [stsr_pkg::TIME_W-1:0] idle_limit_r;
  logic [1:0]                  reg_idx;
  logic                        wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_max_r  <= stsr_pkg::PAYLOAD_MAX_RST;
      buffer_limit_r <= stsr_pkg::BUFFER_LIMIT_RST;
      idle_limit_r   <= stsr_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      if (reg_idx == stsr_pkg::REG_PAYLOAD_MAX) begin
        payload_max_r <= cfg_pwdata[stsr_pkg::PM_W-1:0];
      end
      if (reg_idx == stsr_pkg::REG_BUFFER_LIMIT) begin
        buffer_limit_r <= cfg_pwdata[stsr_pkg::LIM_W-1:0];
      end
      if (reg_idx == stsr_pkg::REG_TIMEOUT) begin
        idle_limit_r <= cfg_pwdata[stsr_pkg::TIME_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == stsr_pkg::REG_PAYLOAD_MAX) begin
      cfg_prdata = stsr_pkg::DATA_W'(payload_max_r);
    end else if (reg_idx == stsr_pkg::REG_BUFFER_LIMIT) begin
      cfg_prdata = stsr_pkg::DATA_W'(buffer_limit_r);
    end else if (reg_idx == stsr_pkg::REG_TIMEOUT) begin
      cfg_prdata = idle_limit_r;
    end
  end

  assign cfg.payload_max  = payload_max_r;
  assign cfg.buffer_limit = buffer_limit_r;
  assign cfg.idle_limit   = idle_limit_r;

endmodule

// ===== rtl/stsr_slot_table.sv =====
// Session slot table: active flags and per-slot session state.
`timescale 1ns / 1ps

module stsr_slot_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stsr_pkg::slot_wr_t          wr,
  input  logic [stsr_pkg::SLOT_W-1:0] rd_idx,
  output stsr_pkg::slot_t             rd
);

  logic [stsr_pkg::SLOTS-1:0]   active_r;
  logic [stsr_pkg::ID_W-1:0]    session_r   [stsr_pkg::SLOTS];
  logic [stsr_pkg::CNT_W-1:0]   total_r     [stsr_pkg::SLOTS];
  logic [stsr_pkg::CNT_W-1:0]   received_r  [stsr_pkg::SLOTS];
  logic [stsr_pkg::BYTES_W-1:0] bytes_r     [stsr_pkg::SLOTS];
  logic [stsr_pkg::TIME_W-1:0]  last_time_r [stsr_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (wr.op_open) begin
      active_r[wr.idx] <= 1'b1;
    end else if (wr.op_free) begin
      active_r[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.op_open) begin
      session_r[wr.idx]   <= wr.session;
      total_r[wr.idx]     <= wr.total;
      bytes_r[wr.idx]     <= wr.bytes;
      received_r[wr.idx]  <= wr.received;
      last_time_r[wr.idx] <= wr.last_time;
    end else if (wr.op_update) begin
      received_r[wr.idx]  <= wr.received;
      last_time_r[wr.idx] <= wr.last_time;
    end
  end

  assign rd.active    = active_r[rd_idx];
  assign rd.session   = session_r[rd_idx];
  assign rd.total     = total_r[rd_idx];
  assign rd.received  = received_r[rd_idx];
  assign rd.bytes     = bytes_r[rd_idx];
  assign rd.last_time = last_time_r[rd_idx];

endmodule

// ===== rtl/stsr_ctrl.sv =====
// Request sequencer: slot walk with shared compare unit, decision step, reply register.
`timescale 1ns / 1ps

module stsr_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  stsr_pkg::cfg_t                  cfg,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [stsr_pkg::MODE_W-1:0]     in_mode,
  input  logic                            in_checksum_ok,
  input  logic [stsr_pkg::ID_W-1:0]       in_session_number,
  input  logic [stsr_pkg::CNT_W-1:0]      in_packet_field,
  input  logic [stsr_pkg::LEN_W-1:0]      in_chunk_len,
  input  logic [stsr_pkg::ID_W-1:0]       in_source_node,
  input  logic [stsr_pkg::TIME_W-1:0]     in_time_now,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [stsr_pkg::CODE_W-1:0]     out_reply_code,
  output logic [stsr_pkg::ID_W-1:0]       out_reply_session,
  output logic [stsr_pkg::ID_W-1:0]       out_reply_node,
  output logic                            out_write_enable,
  output logic [stsr_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [stsr_pkg::BYTES_W-1:0]    out_write_offset,
  output logic [stsr_pkg::LEN_W-1:0]      out_write_length,
  output logic [stsr_pkg::SLOTS-1:0]      out_expired_mask,
  output stsr_pkg::slot_wr_t              wr,
  output logic [stsr_pkg::SLOT_W-1:0]     rd_idx,
  input  stsr_pkg::slot_t                 rd
);

  stsr_pkg::state_t              state_r, state_nxt;
  logic [stsr_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic                          ok_r, ok_nxt;
  logic [stsr_pkg::ID_W-1:0]     sid_r, sid_nxt;
  logic [stsr_pkg::CNT_W-1:0]    pf_r, pf_nxt;
  logic [stsr_pkg::LEN_W-1:0]    plen_r, plen_nxt;
  logic [stsr_pkg::ID_W-1:0]     node_r, node_nxt;
  logic [stsr_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic [stsr_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic [stsr_pkg::SLOT_W-1:0]   idx_r, idx_nxt;
  logic                          found_vld_r, found_vld_nxt;
  logic [stsr_pkg::SLOT_W-1:0]   found_idx_r, found_idx_nxt;
  logic                          free_vld_r, free_vld_nxt;
  logic [stsr_pkg::SLOT_W-1:0]   free_idx_r, free_idx_nxt;
  logic [stsr_pkg::SLOTS-1:0]    mask_r, mask_nxt;

  logic                          out_vld_r, out_vld_nxt;
  logic [stsr_pkg::CODE_W-1:0]   out_code_r, out_code_nxt;
  logic [stsr_pkg::ID_W-1:0]     out_sid_r, out_sid_nxt;
  logic [stsr_pkg::ID_W-1:0]     out_node_r, out_node_nxt;
  logic                          out_we_r, out_we_nxt;
  logic [stsr_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [stsr_pkg::BYTES_W-1:0]  out_off_r, out_off_nxt;
  logic [stsr_pkg::LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [stsr_pkg::SLOTS-1:0]    out_mask_r, out_mask_nxt;

  // shared per-slot compare unit
  logic [stsr_pkg::TIME_W-1:0]   age;
  logic                          expired;
  logic                          match;
  logic [stsr_pkg::SUM_W-1:0]    end_byte;

  assign age      = now_r - rd.last_time;
  assign expired  = rd.active && (age > cfg.idle_limit);
  assign match    = rd.active && (rd.session == sid_r);
  assign end_byte = stsr_pkg::SUM_W'(prod_r) + stsr_pkg::SUM_W'(plen_r);

  assign rd_idx    = (state_r == stsr_pkg::ST_WALK) ? idx_r : found_idx_r;
  assign in_tready = (state_r == stsr_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    ok_nxt        = ok_r;
    sid_nxt       = sid_r;
    pf_nxt        = pf_r;
    plen_nxt      = plen_r;
    node_nxt      = node_r;
    now_nxt       = now_r;
    prod_nxt      = prod_r;
    idx_nxt       = idx_r;
    found_vld_nxt = found_vld_r;
    found_idx_nxt = found_idx_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    mask_nxt      = mask_r;
    out_vld_nxt   = out_vld_r;
    out_code_nxt  = out_code_r;
    out_sid_nxt   = out_sid_r;
    out_node_nxt  = out_node_r;
    out_we_nxt    = out_we_r;
    out_slot_nxt  = out_slot_r;
    out_off_nxt   = out_off_r;
    out_len_nxt   = out_len_r;
    out_mask_nxt  = out_mask_r;
    wr            = '0;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      stsr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt      = in_mode;
          ok_nxt        = in_checksum_ok;
          sid_nxt       = in_session_number;
          pf_nxt        = in_packet_field;
          plen_nxt      = in_chunk_len;
          node_nxt      = in_source_node;
          now_nxt       = in_time_now;
          prod_nxt      = stsr_pkg::PROD_W'(in_packet_field)
                          * stsr_pkg::PROD_W'(cfg.payload_max);
          idx_nxt       = '0;
          found_vld_nxt = 1'b0;
          free_vld_nxt  = 1'b0;
          mask_nxt      = '0;
          if (in_mode != stsr_pkg::MODE_SCAN && !in_checksum_ok) begin
            state_nxt = stsr_pkg::ST_EXEC;
          end else if (in_mode == stsr_pkg::MODE_SCAN || in_mode == stsr_pkg::MODE_START ||
                       in_mode == stsr_pkg::MODE_DATA || in_mode == stsr_pkg::MODE_END) begin
            state_nxt = stsr_pkg::ST_WALK;
          end
        end
      end

      stsr_pkg::ST_WALK: begin
        if (match && !found_vld_r) begin
          found_vld_nxt = 1'b1;
          found_idx_nxt = idx_r;
        end
        if (!rd.active && !free_vld_r) begin
          free_vld_nxt = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (mode_r == stsr_pkg::MODE_SCAN && expired) begin
          wr.op_free      = 1'b1;
          wr.idx          = idx_r;
          mask_nxt[idx_r] = 1'b1;
        end
        if (idx_r == stsr_pkg::SLOT_W'(stsr_pkg::SLOTS - 1)) begin
          state_nxt = stsr_pkg::ST_EXEC;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      stsr_pkg::ST_EXEC: begin
        if (!out_vld_r || out_tready) begin
          state_nxt    = stsr_pkg::ST_IDLE;
          out_vld_nxt  = 1'b1;
          out_code_nxt = stsr_pkg::RC_CRC_ERR;
          out_sid_nxt  = sid_r;
          out_node_nxt = node_r;
          out_we_nxt   = 1'b0;
          out_slot_nxt = '0;
          out_off_nxt  = '0;
          out_len_nxt  = '0;
          out_mask_nxt = '0;
          if (mode_r == stsr_pkg::MODE_SCAN) begin
            out_code_nxt = stsr_pkg::RC_SCAN_DONE;
            out_sid_nxt  = '0;
            out_node_nxt = '0;
            out_mask_nxt = mask_r;
          end else if (!ok_r) begin
            out_code_nxt = stsr_pkg::RC_CRC_ERR;
          end else if (mode_r == stsr_pkg::MODE_START) begin
            if (found_vld_r) begin
              out_code_nxt = stsr_pkg::RC_EXISTS;
              out_slot_nxt = found_idx_r;
            end else if (!free_vld_r) begin
              out_code_nxt = stsr_pkg::RC_NO_SLOT;
            end else if (prod_r > cfg.buffer_limit || prod_r[stsr_pkg::PROD_W-1]) begin
              out_code_nxt = stsr_pkg::RC_NO_MEM;
            end else begin
              wr.op_open   = 1'b1;
              wr.idx       = free_idx_r;
              wr.session   = sid_r;
              wr.total     = pf_r;
              wr.received  = '0;
              wr.bytes     = prod_r[stsr_pkg::BYTES_W-1:0];
              wr.last_time = now_r;
              out_code_nxt = stsr_pkg::RC_START_OK;
              out_slot_nxt = free_idx_r;
            end
          end else if (mode_r == stsr_pkg::MODE_DATA) begin
            if (!found_vld_r) begin
              out_code_nxt = stsr_pkg::RC_INVALID;
            end else begin
              out_slot_nxt = found_idx_r;
              if (pf_r >= rd.total) begin
                out_code_nxt = stsr_pkg::RC_BAD_INDEX;
              end else if (rd.received > pf_r) begin
                out_code_nxt = stsr_pkg::RC_DATA_OK;
              end else if (end_byte > stsr_pkg::SUM_W'(rd.bytes)) begin
                out_code_nxt = stsr_pkg::RC_OVERFLOW;
              end else begin
                wr.op_update = 1'b1;
                wr.idx       = found_idx_r;
                wr.received  = pf_r + 1'b1;
                wr.last_time = now_r;
                out_code_nxt = stsr_pkg::RC_DATA_OK;
                out_we_nxt   = 1'b1;
                out_off_nxt  = prod_r[stsr_pkg::BYTES_W-1:0];
                out_len_nxt  = plen_r;
              end
            end
          end else begin
            if (!found_vld_r) begin
              out_code_nxt = stsr_pkg::RC_INVALID;
            end else begin
              out_slot_nxt = found_idx_r;
              if (rd.received != rd.total) begin
                out_code_nxt = stsr_pkg::RC_MISSING;
              end else begin
                wr.op_free   = 1'b1;
                wr.idx       = found_idx_r;
                out_code_nxt = stsr_pkg::RC_END_OK;
              end
            end
          end
        end
      end

      default: begin
        state_nxt = stsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= stsr_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    ok_r        <= ok_nxt;
    sid_r       <= sid_nxt;
    pf_r        <= pf_nxt;
    plen_r      <= plen_nxt;
    node_r      <= node_nxt;
    now_r       <= now_nxt;
    prod_r      <= prod_nxt;
    idx_r       <= idx_nxt;
    found_vld_r <= found_vld_nxt;
    found_idx_r <= found_idx_nxt;
    free_vld_r  <= free_vld_nxt;
    free_idx_r  <= free_idx_nxt;
    mask_r      <= mask_nxt;
    out_code_r  <= out_code_nxt;
    out_sid_r   <= out_sid_nxt;
    out_node_r  <= out_node_nxt;
    out_we_r    <= out_we_nxt;
    out_slot_r  <= out_slot_nxt;
    out_off_r   <= out_off_nxt;
    out_len_r   <= out_len_nxt;
    out_mask_r  <= out_mask_nxt;
  end

  assign out_tvalid        = out_vld_r;
  assign out_reply_code    = out_code_r;
  assign out_reply_session = out_sid_r;
  assign out_reply_node    = out_node_r;
  assign out_write_enable  = out_we_r;
  assign out_slot_index    = out_slot_r;
  assign out_write_offset  = out_off_r;
  assign out_write_length  = out_len_r;
  assign out_expired_mask  = out_mask_r;

endmodule

// ===== rtl/segmented_transfer_session_receiver.sv =====
// Segmented transfer session receiver top level.
//
// Input stream: one request per frame (start, data, end, ack, timeout scan),
// mode and checksum flag in in_tuser, frame fields in in_tdata.
// Output stream: at most one reply per request (reply code, echoed session
// and node, slot, payload write command, expired mask). Ack and unknown
// frames with a good checksum get no reply.
// Configuration: APB-style port, payload_max at 0x0, buffer_limit at 0x4,
// idle_limit at 0x8; write only while no request is in flight.
// Timing: a request walks the 3 session slots through one shared compare
// unit, one slot per cycle, then takes a decision step that registers the
// reply; a request with a bad checksum, other than a scan, skips the walk.
// in_tready is low from acceptance until the decision step, so no new
// request is taken meanwhile; ack frames with a good checksum leave it high.
// A finished reply waits in the output register while the next request is
// taken; if the receiver stalls, the decision step holds until it is free.
// Reset (rst_n, synchronous) frees all slots and loads the register defaults.
`timescale 1ns / 1ps

module segmented_transfer_session_receiver (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // session_number, packet_field, chunk_len, source_node, time_now
  input  logic [stsr_pkg::IN_DATA_W-1:0]     in_tdata,
  // mode, checksum_ok
  input  logic [stsr_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // reply_session, reply_node, slot_index, write_offset, write_length, expired_mask
  output logic [stsr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // reply_code, write_enable
  output logic [stsr_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [stsr_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [stsr_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic [stsr_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  stsr_pkg::cfg_t                 cfg;
  stsr_pkg::slot_wr_t             wr;
  stsr_pkg::slot_t                rd;
  logic [stsr_pkg::SLOT_W-1:0]    rd_idx;

  logic [stsr_pkg::CODE_W-1:0]    reply_code;
  logic [stsr_pkg::ID_W-1:0]      reply_session;
  logic [stsr_pkg::ID_W-1:0]      reply_node;
  logic                           write_enable;
  logic [stsr_pkg::SLOT_W-1:0]    slot_index;
  logic [stsr_pkg::BYTES_W-1:0]   write_offset;
  logic [stsr_pkg::LEN_W-1:0]     write_length;
  logic [stsr_pkg::SLOTS-1:0]     expired_mask;

  stsr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  stsr_slot_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd     (rd)
  );

  stsr_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_mode           (in_tuser[2:0]),
    .in_checksum_ok    (in_tuser[3]),
    .in_session_number (in_tdata[15:0]),
    .in_packet_field   (in_tdata[31:16]),
    .in_chunk_len      (in_tdata[38:32]),
    .in_source_node    (in_tdata[54:39]),
    .in_time_now       (in_tdata[86:55]),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_reply_code    (reply_code),
    .out_reply_session (reply_session),
    .out_reply_node    (reply_node),
    .out_write_enable  (write_enable),
    .out_slot_index    (slot_index),
    .out_write_offset  (write_offset),
    .out_write_length  (write_length),
    .out_expired_mask  (expired_mask),
    .wr                (wr),
    .rd_idx            (rd_idx),
    .rd                (rd)
  );

  assign out_tdata = {6'd0, expired_mask, write_length, write_offset, slot_index,
                      reply_node, reply_session};
  assign out_tuser = {write_enable, reply_code};

endmodule
